// ===== design/cpio_pkg.sv =====
// ----------------------------------------------------------------------------
// cpio_pkg
// shared record types, codes and character tables of the cpio newc parser
// ----------------------------------------------------------------------------
`default_nettype none

package cpio_pkg;

   // result kinds
   localparam logic [2:0] KIND_HEADER   = 3'd0;
   localparam logic [2:0] KIND_NAME     = 3'd1;
   localparam logic [2:0] KIND_DATA     = 3'd2;
   localparam logic [2:0] KIND_ENTRY    = 3'd3;
   localparam logic [2:0] KIND_ARCHIVE  = 3'd4;
   localparam logic [2:0] KIND_ERROR    = 3'd5;

   // error codes
   localparam logic [2:0] ERR_MAGIC     = 3'd0;
   localparam logic [2:0] ERR_HEX       = 3'd1;
   localparam logic [2:0] ERR_MODE      = 3'd2;
   localparam logic [2:0] ERR_NAME_LONG = 3'd3;
   localparam logic [2:0] ERR_TRUNC     = 3'd4;

   // header layout
   localparam logic [6:0] HDR_LAST      = 7'd109;
   localparam logic [6:0] MAGIC_LEN     = 7'd6;
   localparam int unsigned TRAILER_LEN  = 11;

   // header flag bits
   localparam int unsigned FL_MAGIC     = 0;
   localparam int unsigned FL_MODE      = 1;
   localparam int unsigned FL_SIZE      = 2;
   localparam int unsigned FL_NSIZE     = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  byte_value;
      logic [31:0] file_mode;
      logic [31:0] file_size;
      logic [11:0] name_size;
      logic        last_of_run;
      logic [2:0]  error_code;
   } rec_type;

   // second record of a byte is only ever an end or error record
   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] error_code;
   } tail_type;

   typedef struct packed {
      logic     two;
      rec_type  first;
      tail_type second;
   } pair_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } q_stat_type;

   function automatic rec_type tail_to_rec(input tail_type t);
      rec_type r;
      r            = '0;
      r.kind       = t.kind;
      r.error_code = t.error_code;
      return r;
   endfunction

   // bit 4 set marks a character that is no uppercase hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h37)};
      end else begin
         v = 5'b10000;
      end
      return v;
   endfunction

   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = "0";
         3'd1:    c = "7";
         3'd2:    c = "0";
         3'd3:    c = "7";
         3'd4:    c = "0";
         3'd5:    c = "1";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] trailer_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "T";
         4'd1:    c = "R";
         4'd2:    c = "A";
         4'd3:    c = "I";
         4'd4:    c = "L";
         4'd5:    c = "E";
         4'd6:    c = "R";
         4'd7:    c = "!";
         4'd8:    c = "!";
         4'd9:    c = "!";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/cpio_queue.sv =====
// ----------------------------------------------------------------------------
// cpio_queue
// two-entry queue of per-byte record pairs between parser and serializer
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cpio_pkg::pair_type   push_data,
   input  wire logic                 pop,
   output cpio_pkg::pair_type        head,
   output cpio_pkg::q_stat_type      stat
);
   import cpio_pkg::*;

   pair_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != 2'd0);
   assign stat.not_full  = (count_ff != 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/cpio_front.sv =====
// ----------------------------------------------------------------------------
// cpio_front
// byte parser: header decode, name and data tracking, alignment, errors
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_front #(
   parameter int unsigned NAME_LIMIT = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_eob,
   input  wire cpio_pkg::q_stat_type q_stat,
   output logic                      push,
   output cpio_pkg::pair_type        push_data
);
   import cpio_pkg::*;

   localparam int unsigned CNT_W = $clog2(NAME_LIMIT);

   typedef enum logic [6:0] {
      PH_HDR  = 7'b0000001,
      PH_NAME = 7'b0000010,
      PH_NPAD = 7'b0000100,
      PH_DATA = 7'b0001000,
      PH_DPAD = 7'b0010000,
      PH_DONE = 7'b0100000,
      PH_ERR  = 7'b1000000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       align_ff, align_in;
   logic [6:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [CNT_W-1:0] name_cnt_ff, name_cnt_in;
   logic [31:0]      data_ff, data_in;
   logic [31:0]      mode_ff, mode_in;
   logic [31:0]      size_ff, size_in;
   logic [31:0]      nsize_ff, nsize_in;
   logic [3:0]       flags_ff, flags_in;
   logic             trailer_ff, trailer_in;

   logic             accept;
   logic             main_v;
   rec_type          main_rec;
   logic             tail_v;
   tail_type         tail_rec;
   logic             do_end;
   logic             name_last;
   logic [4:0]       hexv;

   assign in_ready = q_stat.not_full;
   assign accept   = in_valid && q_stat.not_full;

   always_comb begin
      phase_in    = phase_ff;
      align_in    = align_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      name_cnt_in = name_cnt_ff;
      data_in     = data_ff;
      mode_in     = mode_ff;
      size_in     = size_ff;
      nsize_in    = nsize_ff;
      flags_in    = flags_ff;
      trailer_in  = trailer_ff;
      main_v      = 1'b0;
      main_rec    = '0;
      tail_v      = 1'b0;
      tail_rec    = '0;
      do_end      = 1'b0;
      hexv        = hex_digit(in_byte);
      name_last   = (({1'b0, name_cnt_ff} + 1'b1) == nsize_ff[CNT_W:0]);
      push_data   = '0;

      if (accept && phase_ff != PH_DONE && phase_ff != PH_ERR) begin
         align_in = align_ff + 2'd1;
         case (phase_ff)
            PH_HDR: begin
               if (hdr_cnt_ff < MAGIC_LEN) begin
                  if (in_byte != magic_char(hdr_cnt_ff[2:0])) begin
                     flags_in[FL_MAGIC] = 1'b1;
                  end
               end else if (hdr_cnt_ff inside {[7'd14:7'd21]}) begin
                  mode_in = {mode_ff[27:0], hexv[3:0]};
                  if (hexv[4]) flags_in[FL_MODE] = 1'b1;
               end else if (hdr_cnt_ff inside {[7'd54:7'd61]}) begin
                  size_in = {size_ff[27:0], hexv[3:0]};
                  if (hexv[4]) flags_in[FL_SIZE] = 1'b1;
               end else if (hdr_cnt_ff inside {[7'd94:7'd101]}) begin
                  nsize_in = {nsize_ff[27:0], hexv[3:0]};
                  if (hexv[4]) flags_in[FL_NSIZE] = 1'b1;
               end

               if (hdr_cnt_ff != HDR_LAST) begin
                  hdr_cnt_in = hdr_cnt_ff + 7'd1;
               end else begin
                  main_v     = 1'b1;
                  main_rec.kind = KIND_ERROR;
                  if (flags_ff[FL_MAGIC]) begin
                     main_rec.error_code = ERR_MAGIC;
                     phase_in = PH_ERR;
                  end else if (flags_ff[FL_SIZE] || flags_ff[FL_MODE]) begin
                     main_rec.error_code = ERR_HEX;
                     phase_in = PH_ERR;
                  end else if (mode_ff == 32'hFFFF_FFFF) begin
                     main_rec.error_code = ERR_MODE;
                     phase_in = PH_ERR;
                  end else if (flags_ff[FL_NSIZE]) begin
                     main_rec.error_code = ERR_HEX;
                     phase_in = PH_ERR;
                  end else if ({1'b0, nsize_ff} >= 33'(NAME_LIMIT)) begin
                     main_rec.error_code = ERR_NAME_LONG;
                     phase_in = PH_ERR;
                  end else begin
                     main_rec.kind      = KIND_HEADER;
                     main_rec.file_mode = mode_ff;
                     main_rec.file_size = size_ff;
                     main_rec.name_size = nsize_ff[11:0];
                     data_in     = size_ff;
                     name_cnt_in = '0;
                     hdr_cnt_in  = 7'd0;
                     if (nsize_ff != 32'd0) begin
                        phase_in = PH_NAME;
                     end else begin
                        trailer_in = 1'b0;
                        if (align_in == 2'd0) begin
                           if (size_ff != 32'd0) phase_in = PH_DATA;
                           else do_end = 1'b1;
                        end else begin
                           phase_in = PH_NPAD;
                        end
                     end
                  end
               end
            end
            PH_NAME: begin
               if (name_cnt_ff < CNT_W'(TRAILER_LEN) &&
                   in_byte != trailer_char(name_cnt_ff[3:0])) begin
                  trailer_in = 1'b0;
               end
               main_v               = 1'b1;
               main_rec.kind        = KIND_NAME;
               main_rec.byte_value  = in_byte;
               main_rec.last_of_run = name_last;
               if (name_last) begin
                  if (nsize_ff < 32'(TRAILER_LEN)) trailer_in = 1'b0;
                  if (align_in == 2'd0) begin
                     if (data_ff != 32'd0) phase_in = PH_DATA;
                     else do_end = 1'b1;
                  end else begin
                     phase_in = PH_NPAD;
                  end
               end else begin
                  name_cnt_in = name_cnt_ff + 1'b1;
               end
            end
            PH_NPAD: begin
               if (align_in == 2'd0) begin
                  if (data_ff != 32'd0) phase_in = PH_DATA;
                  else do_end = 1'b1;
               end
            end
            PH_DATA: begin
               data_in              = data_ff - 32'd1;
               main_v               = 1'b1;
               main_rec.kind        = KIND_DATA;
               main_rec.byte_value  = in_byte;
               main_rec.last_of_run = (data_in == 32'd0);
               if (data_in == 32'd0) begin
                  if (align_in == 2'd0) do_end = 1'b1;
                  else phase_in = PH_DPAD;
               end
            end
            PH_DPAD: begin
               if (align_in == 2'd0) do_end = 1'b1;
            end
            default: begin
               phase_in = PH_ERR;
            end
         endcase

         // entry end, or archive end on the trailer entry
         if (do_end) begin
            tail_v = 1'b1;
            if (trailer_in) begin
               tail_rec.kind = KIND_ARCHIVE;
               phase_in      = PH_DONE;
            end else begin
               tail_rec.kind = KIND_ENTRY;
               phase_in      = PH_HDR;
               hdr_cnt_in    = 7'd0;
               data_in       = 32'd0;
               mode_in       = 32'd0;
               size_in       = 32'd0;
               nsize_in      = 32'd0;
               flags_in      = 4'd0;
               trailer_in    = 1'b1;
            end
         end

         // buffer ends before the archive does: error replaces any entry end
         if (in_eob && phase_in != PH_DONE && phase_in != PH_ERR) begin
            tail_v              = 1'b1;
            tail_rec.kind       = KIND_ERROR;
            tail_rec.error_code = ERR_TRUNC;
            phase_in            = PH_ERR;
         end
      end

      if (main_v) begin
         push_data.first  = main_rec;
         push_data.second = tail_rec;
         push_data.two    = tail_v;
      end else begin
         push_data.first  = tail_to_rec(tail_rec);
      end
      push = main_v || tail_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         align_ff    <= 2'd0;
         hdr_cnt_ff  <= 7'd0;
         name_cnt_ff <= '0;
         data_ff     <= 32'd0;
         mode_ff     <= 32'd0;
         size_ff     <= 32'd0;
         nsize_ff    <= 32'd0;
         flags_ff    <= 4'd0;
         trailer_ff  <= 1'b1;
      end else begin
         phase_ff    <= phase_in;
         align_ff    <= align_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         name_cnt_ff <= name_cnt_in;
         data_ff     <= data_in;
         mode_ff     <= mode_in;
         size_ff     <= size_in;
         nsize_ff    <= nsize_in;
         flags_ff    <= flags_in;
         trailer_ff  <= trailer_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/cpio_back.sv =====
// ----------------------------------------------------------------------------
// cpio_back
// serializer: sends the one or two records of each queued byte in turn
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cpio_pkg::pair_type   head,
   input  wire cpio_pkg::q_stat_type q_stat,
   output logic                      pop,
   input  wire logic                 out_ready,
   output logic                      out_valid,
   output cpio_pkg::rec_type         out_rec
);
   import cpio_pkg::*;

   logic    out_v_ff, out_v_in;
   logic    sub_ff, sub_in;
   rec_type rec_ff;
   logic    load;
   logic    take;

   always_comb begin
      load     = !out_v_ff || out_ready;
      take     = load && q_stat.not_empty;
      pop      = take && (sub_ff || !head.two);
      out_v_in = load ? q_stat.not_empty : out_v_ff;
      sub_in   = take ? (!sub_ff && head.two) : sub_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rec_ff <= sub_ff ? tail_to_rec(head.second) : head.first;
      end
   end

   assign out_valid = out_v_ff;
   assign out_rec   = rec_ff;

endmodule

`default_nettype wire

// ===== design/cpio_newc_stream_parser.sv =====
// ----------------------------------------------------------------------------
// cpio_newc_stream_parser
// streaming parser of cpio newc archives, one archive byte per request
// ----------------------------------------------------------------------------
// path: the first record of a byte passes the queue, then the output register, to rsp
// throughput: one byte per cycle while rsp_tready is high; a byte with two
//   records (header, name or data byte with entry end or truncation error)
//   holds the single-record output register for both, absorbed by the two-entry queue
// reset: synchronous, active high; queue emptied, parser at offset 0 in header
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_newc_stream_parser #(
   parameter int unsigned NAME_LIMIT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // in_byte
   input  wire logic        req_tlast,   // end_of_buffer
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // byte_value, file_mode, file_size,
                                         // name_size, error_code, one zero pad
   output logic [2:0]       rsp_tuser,   // kind
   output logic             rsp_tlast    // last_of_run
);
   import cpio_pkg::*;

   // front to queue
   logic       push;
   pair_type   push_data;
   // queue to back
   pair_type   head;
   q_stat_type q_stat;
   logic       pop;
   rec_type    out_rec;

   // parser: classifies every byte and builds its records
   cpio_front #(
      .NAME_LIMIT (NAME_LIMIT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_eob    (req_tlast),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   // decouples parser from the result side stall
   cpio_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (q_stat)
   );

   // hands records out one at a time from a registered stage
   cpio_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_rec   (out_rec)
   );

   // payload packing, lowest field in the lowest bits
   assign rsp_tdata = {1'b0, out_rec.error_code, out_rec.name_size,
                       out_rec.file_size, out_rec.file_mode, out_rec.byte_value};
   assign rsp_tuser = out_rec.kind;
   assign rsp_tlast = out_rec.last_of_run;

endmodule

`default_nettype wire
